[design/trs_pkg.sv]
// Shared widths, word types and constants for the TRS transform-to-matrix pipeline.
package trs_pkg;

	localparam int QW        = 16;
	localparam int SW        = 16;
	localparam int PW        = 32;
	localparam int QPROD_W   = 32;
	localparam int ELEM_W    = 34;
	localparam int MUL_W     = ELEM_W + SW;
	localparam int FRAC_DROP = 22;

	localparam logic [1:0] COL_FIRST = 2'd0;
	localparam logic [1:0] COL_LAST  = 2'd3;

	localparam logic signed [ELEM_W-1:0] ONE_Q30    = 34'sd1073741824;
	localparam logic signed [PW-1:0]     ONE_Q16    = 32'sd65536;
	localparam logic signed [MUL_W-1:0]  ROUND_HALF = 50'sd2097152;

	typedef logic signed [QW-1:0]      quat_t;
	typedef logic signed [SW-1:0]      scale_t;
	typedef logic signed [PW-1:0]      pos_t;
	typedef logic signed [QPROD_W-1:0] qprod_t;
	typedef logic signed [ELEM_W-1:0]  elem_t;
	typedef logic signed [MUL_W-1:0]   mul_t;

	typedef struct packed {
		qprod_t xx;
		qprod_t yy;
		qprod_t zz;
		qprod_t xy;
		qprod_t xz;
		qprod_t yz;
		qprod_t wx;
		qprod_t wy;
		qprod_t wz;
		scale_t sx;
		scale_t sy;
		scale_t sz;
		pos_t   px;
		pos_t   py;
		pos_t   pz;
	} prod_word_t;

	typedef struct packed {
		logic [1:0] col;
		elem_t      e0;
		elem_t      e1;
		elem_t      e2;
		scale_t     scl;
	} col_word_t;

endpackage

[design/trs_prod.sv]
// First stage: registers the nine quaternion cross products with the scales and position.
module trs_prod import trs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  quat_t      quat_x,
	input  quat_t      quat_y,
	input  quat_t      quat_z,
	input  quat_t      quat_w,
	input  scale_t     scale_x,
	input  scale_t     scale_y,
	input  scale_t     scale_z,
	input  pos_t       pos_x,
	input  pos_t       pos_y,
	input  pos_t       pos_z,
	output logic       out_valid,
	input  logic       out_ready,
	output prod_word_t out_word
);

	logic       valid_s1;
	prod_word_t word_s1;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_word  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1.xx <= qprod_t'(quat_x * quat_x);
			word_s1.yy <= qprod_t'(quat_y * quat_y);
			word_s1.zz <= qprod_t'(quat_z * quat_z);
			word_s1.xy <= qprod_t'(quat_x * quat_y);
			word_s1.xz <= qprod_t'(quat_x * quat_z);
			word_s1.yz <= qprod_t'(quat_y * quat_z);
			word_s1.wx <= qprod_t'(quat_w * quat_x);
			word_s1.wy <= qprod_t'(quat_w * quat_y);
			word_s1.wz <= qprod_t'(quat_w * quat_z);
			word_s1.sx <= scale_x;
			word_s1.sy <= scale_y;
			word_s1.sz <= scale_z;
			word_s1.px <= pos_x;
			word_s1.py <= pos_y;
			word_s1.pz <= pos_z;
		end
	end

endmodule

[design/trs_col_seq.sv]
// Second stage: forms the rotation elements and sends out one matrix column per cycle while the output is ready.
module trs_col_seq import trs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  prod_word_t in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output col_word_t  out_word
);

	logic       valid_s2;
	logic [1:0] cnt_q;
	elem_t      m_s2 [3][3];
	scale_t     sx_s2;
	scale_t     sy_s2;
	scale_t     sz_s2;
	pos_t       px_s2;
	pos_t       py_s2;
	pos_t       pz_s2;
	logic       load;

	function automatic elem_t diag(input qprod_t a, input qprod_t b);
		elem_t s;
		s = elem_t'(a) + elem_t'(b);
		return ONE_Q30 - (s <<< 1);
	endfunction

	function automatic elem_t offd_add(input qprod_t a, input qprod_t b);
		elem_t s;
		s = elem_t'(a) + elem_t'(b);
		return s <<< 1;
	endfunction

	function automatic elem_t offd_sub(input qprod_t a, input qprod_t b);
		elem_t s;
		s = elem_t'(a) - elem_t'(b);
		return s <<< 1;
	endfunction

	assign in_ready  = !valid_s2 || (out_ready && cnt_q == COL_LAST);
	assign load      = in_valid && in_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_q    <= COL_FIRST;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
			cnt_q    <= COL_FIRST;
		end else if (out_ready) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_s2[0][0] <= diag(in_word.yy, in_word.zz);
			m_s2[0][1] <= offd_add(in_word.xy, in_word.wz);
			m_s2[0][2] <= offd_sub(in_word.xz, in_word.wy);
			m_s2[1][0] <= offd_sub(in_word.xy, in_word.wz);
			m_s2[1][1] <= diag(in_word.xx, in_word.zz);
			m_s2[1][2] <= offd_add(in_word.yz, in_word.wx);
			m_s2[2][0] <= offd_add(in_word.xz, in_word.wy);
			m_s2[2][1] <= offd_sub(in_word.yz, in_word.wx);
			m_s2[2][2] <= diag(in_word.xx, in_word.yy);
			sx_s2      <= in_word.sx;
			sy_s2      <= in_word.sy;
			sz_s2      <= in_word.sz;
			px_s2      <= in_word.px;
			py_s2      <= in_word.py;
			pz_s2      <= in_word.pz;
		end
	end

	always_comb begin
		out_word.col = cnt_q;
		case (cnt_q)
			2'd0: begin
				out_word.e0  = m_s2[0][0];
				out_word.e1  = m_s2[0][1];
				out_word.e2  = m_s2[0][2];
				out_word.scl = sx_s2;
			end
			2'd1: begin
				out_word.e0  = m_s2[1][0];
				out_word.e1  = m_s2[1][1];
				out_word.e2  = m_s2[1][2];
				out_word.scl = sy_s2;
			end
			2'd2: begin
				out_word.e0  = m_s2[2][0];
				out_word.e1  = m_s2[2][1];
				out_word.e2  = m_s2[2][2];
				out_word.scl = sz_s2;
			end
			default: begin
				out_word.e0  = elem_t'(px_s2);
				out_word.e1  = elem_t'(py_s2);
				out_word.e2  = elem_t'(pz_s2);
				out_word.scl = '0;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_cnt_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != COL_FIRST |-> valid_s2)
		else $error("column counter running without a word in the stage");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_ready && cnt_q != COL_LAST |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("column counter did not advance after a taken column");

	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_s2 && cnt_q == COL_FIRST)
		else $error("new word did not start at column zero");
`endif

endmodule

[design/trs_col_scale.sv]
// Third and fourth stages: scale, round to Q16.16 except the position column, hold the output.
module trs_col_scale import trs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  col_word_t  in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] column,
	output pos_t       row0,
	output pos_t       row1,
	output pos_t       row2,
	output pos_t       row3,
	output logic       final_col
);

	logic       valid_s3;
	logic [1:0] col_s3;
	mul_t       mul_s3 [3];
	logic       valid_s4;
	logic [1:0] col_s4;
	pos_t       row_s4 [3];
	logic       ready_s4;
	elem_t      e_in [3];
	mul_t       sum  [3];
	pos_t       rnd  [3];

	assign ready_s4 = !valid_s4 || out_ready;
	assign in_ready = !valid_s3 || ready_s4;

	assign e_in[0] = in_word.e0;
	assign e_in[1] = in_word.e1;
	assign e_in[2] = in_word.e2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			col_s3 <= in_word.col;
			for (int i = 0; i < 3; i++) begin
				if (in_word.col == COL_LAST) begin
					mul_s3[i] <= mul_t'(e_in[i]);
				end else begin
					mul_s3[i] <= mul_t'(e_in[i] * in_word.scl);
				end
			end
		end
	end

	// Round to nearest with ties upward; the result always fits in 32 bits.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = mul_s3[i] + ROUND_HALF;
			rnd[i] = pos_t'($signed(sum[i][MUL_W-1:FRAC_DROP]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s4) begin
			col_s4 <= col_s3;
			for (int i = 0; i < 3; i++) begin
				if (col_s3 == COL_LAST) begin
					row_s4[i] <= mul_s3[i][PW-1:0];
				end else begin
					row_s4[i] <= rnd[i];
				end
			end
		end
	end

	assign out_valid = valid_s4;
	assign column    = col_s4;
	assign row0      = row_s4[0];
	assign row1      = row_s4[1];
	assign row2      = row_s4[2];
	assign final_col = (col_s4 == COL_LAST);
	assign row3      = (col_s4 == COL_LAST) ? ONE_Q16 : '0;

endmodule

[design/trs_transform_to_matrix.sv]
// Top level of the TRS transform-to-matrix block: quaternion, scale and position in, four columns out.
// Column 0 is valid once the accepted transform passes the product, column, scale and output registers;
// columns 1 to 3 follow it in order when the output is not stalled.
// All columns share one output channel; new transforms enter while earlier ones are still in flight.
// Reset clears only the stage valid bits and the column counter; data registers are not reset.
module trs_transform_to_matrix import trs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  quat_t      quat_x,
	input  quat_t      quat_y,
	input  quat_t      quat_z,
	input  quat_t      quat_w,
	input  scale_t     scale_x,
	input  scale_t     scale_y,
	input  scale_t     scale_z,
	input  pos_t       pos_x,
	input  pos_t       pos_y,
	input  pos_t       pos_z,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] column,
	output pos_t       row0,
	output pos_t       row1,
	output pos_t       row2,
	output pos_t       row3,
	output logic       final_col
);

	logic       prod_valid;
	logic       prod_ready;
	prod_word_t prod_word;
	logic       col_valid;
	logic       col_ready;
	col_word_t  col_word;

	trs_prod u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.quat_w    (quat_w),
		.scale_x   (scale_x),
		.scale_y   (scale_y),
		.scale_z   (scale_z),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_word  (prod_word)
	);

	trs_col_seq u_col_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (prod_ready),
		.in_word   (prod_word),
		.out_valid (col_valid),
		.out_ready (col_ready),
		.out_word  (col_word)
	);

	trs_col_scale u_col_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (col_valid),
		.in_ready  (col_ready),
		.in_word   (col_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.column    (column),
		.row0      (row0),
		.row1      (row1),
		.row2      (row2),
		.row3      (row3),
		.final_col (final_col)
	);

endmodule

[tb/sv/trs_transform_to_matrix_test.sv]
// Testbench for trs_transform_to_matrix: random and directed transforms checked column by column.
module trs_transform_to_matrix_test;
	import trs_pkg::*;

	typedef struct packed {
		quat_t  qx;
		quat_t  qy;
		quat_t  qz;
		quat_t  qw;
		scale_t sx;
		scale_t sy;
		scale_t sz;
		pos_t   px;
		pos_t   py;
		pos_t   pz;
	} xform_t;

	typedef struct packed {
		logic [1:0] col;
		pos_t       r0;
		pos_t       r1;
		pos_t       r2;
		pos_t       r3;
		logic       fin;
	} column_t;

	class column_ledger;
		column_t pending[$];
		int      mismatches;

		function pos_t scale_round(longint e30, longint s88);
			longint p;
			p = e30 * s88 + (longint'(1) << (FRAC_DROP - 1));
			p = p >>> FRAC_DROP;
			if (p > longint'(32'sh7fffffff)) begin
				p = longint'(32'sh7fffffff);
			end else if (p < longint'(32'sh80000000)) begin
				p = longint'(32'sh80000000);
			end
			return pos_t'(p);
		endfunction

		function void note_transform(xform_t t);
			longint qx, qy, qz, qw, sx, sy, sz, one;
			column_t c;
			qx = t.qx;
			qy = t.qy;
			qz = t.qz;
			qw = t.qw;
			sx = t.sx;
			sy = t.sy;
			sz = t.sz;
			one = longint'(1) << 30;
			c.r3 = '0;
			c.fin = 1'b0;
			c.col = COL_FIRST;
			c.r0 = scale_round(one - 2 * (qy * qy + qz * qz), sx);
			c.r1 = scale_round(2 * (qx * qy + qw * qz), sx);
			c.r2 = scale_round(2 * (qx * qz - qw * qy), sx);
			pending.push_back(c);
			c.col = 2'd1;
			c.r0 = scale_round(2 * (qx * qy - qw * qz), sy);
			c.r1 = scale_round(one - 2 * (qx * qx + qz * qz), sy);
			c.r2 = scale_round(2 * (qy * qz + qw * qx), sy);
			pending.push_back(c);
			c.col = 2'd2;
			c.r0 = scale_round(2 * (qx * qz + qw * qy), sz);
			c.r1 = scale_round(2 * (qy * qz - qw * qx), sz);
			c.r2 = scale_round(one - 2 * (qx * qx + qy * qy), sz);
			pending.push_back(c);
			c.col = COL_LAST;
			c.r0 = t.px;
			c.r1 = t.py;
			c.r2 = t.pz;
			c.r3 = ONE_Q16;
			c.fin = 1'b1;
			pending.push_back(c);
		endfunction

		function void check_column(column_t got);
			column_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected word: col %0d rows %h %h %h %h final %b",
						got.col, got.r0, got.r1, got.r2, got.r3, got.fin);
				end
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch: expected col %0d rows %h %h %h %h final %b",
							want.col, want.r0, want.r1, want.r2, want.r3, want.fin);
						$display("          actual   col %0d rows %h %h %h %h final %b",
							got.col, got.r0, got.r1, got.r2, got.r3, got.fin);
					end
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	quat_t      quat_x, quat_y, quat_z, quat_w;
	scale_t     scale_x, scale_y, scale_z;
	pos_t       pos_x, pos_y, pos_z;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] column;
	pos_t       row0, row1, row2, row3;
	logic       final_col;

	column_ledger ledger = new();
	bit           sender_calm;
	bit           sink_calm;

	trs_transform_to_matrix dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.quat_w    (quat_w),
		.scale_x   (scale_x),
		.scale_y   (scale_y),
		.scale_z   (scale_z),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.column    (column),
		.row0      (row0),
		.row1      (row1),
		.row2      (row2),
		.row3      (row3),
		.final_col (final_col)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 400000);
		$display("FAILURE");
		$finish;
	end

	function automatic xform_t make_xform(int qx, int qy, int qz, int qw,
		int sx, int sy, int sz, int px, int py, int pz);
		xform_t t;
		t.qx = quat_t'(qx);
		t.qy = quat_t'(qy);
		t.qz = quat_t'(qz);
		t.qw = quat_t'(qw);
		t.sx = scale_t'(sx);
		t.sy = scale_t'(sy);
		t.sz = scale_t'(sz);
		t.px = pos_t'(px);
		t.py = pos_t'(py);
		t.pz = pos_t'(pz);
		return t;
	endfunction

	function automatic logic [15:0] rand_half();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h00000000;
			default: return $urandom;
		endcase
	endfunction

	// About half rotations close to unit length, the rest arbitrary quaternions.
	function automatic xform_t rand_xform();
		xform_t t;
		int     axis;
		t.qx = rand_half();
		t.qy = rand_half();
		t.qz = rand_half();
		t.qw = rand_half();
		if ($urandom_range(0, 1) == 0) begin
			axis = $urandom_range(0, 3);
			t.qx = quat_t'($signed($urandom_range(0, 8192)) - 4096);
			t.qy = quat_t'($signed($urandom_range(0, 8192)) - 4096);
			t.qz = quat_t'($signed($urandom_range(0, 8192)) - 4096);
			t.qw = quat_t'($signed($urandom_range(0, 8192)) - 4096);
			case (axis)
				0: t.qx = $urandom_range(0, 1) ? 16'sh7f00 : -16'sh7f00;
				1: t.qy = $urandom_range(0, 1) ? 16'sh7f00 : -16'sh7f00;
				2: t.qz = $urandom_range(0, 1) ? 16'sh7f00 : -16'sh7f00;
				default: t.qw = $urandom_range(0, 1) ? 16'sh7f00 : -16'sh7f00;
			endcase
		end
		t.sx = rand_half();
		t.sy = rand_half();
		t.sz = rand_half();
		t.px = rand_word();
		t.py = rand_word();
		t.pz = rand_word();
		return t;
	endfunction

	task automatic send_transform(xform_t t, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		quat_x   <= t.qx;
		quat_y   <= t.qy;
		quat_z   <= t.qz;
		quat_w   <= t.qw;
		scale_x  <= t.sx;
		scale_y  <= t.sy;
		scale_z  <= t.sz;
		pos_x    <= t.px;
		pos_y    <= t.py;
		pos_z    <= t.pz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ledger.note_transform(t);
	endtask

	initial begin
		column_t got;
		int      stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = sink_calm ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got.col = column;
			got.r0 = row0;
			got.r1 = row1;
			got.r2 = row2;
			got.r3 = row3;
			got.fin = final_col;
			ledger.check_column(got);
		end
	end

	initial begin
		xform_t directed[$];
		int     phase;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_ready = 1'b0;
		quat_x    = '0;
		quat_y    = '0;
		quat_z    = '0;
		quat_w    = '0;
		scale_x   = '0;
		scale_y   = '0;
		scale_z   = '0;
		pos_x     = '0;
		pos_y     = '0;
		pos_z     = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity rotation, null quaternion, extremes of every field and degenerate scales.
		directed.push_back(make_xform(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_xform(0, 0, 0, 32767, 256, 256, 256, 0, 0, 0));
		directed.push_back(make_xform(0, 0, 0, -32768, 256, 256, 256, 65536, -65536, 0));
		directed.push_back(make_xform(32767, 32767, 32767, 32767, 32767, 32767, 32767,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		directed.push_back(make_xform(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, 32'h80000000, 32'h80000000, 32'h80000000));
		directed.push_back(make_xform(-32768, 0, 0, 0, 32767, -32768, 1, 1, -1, 0));
		directed.push_back(make_xform(0, -32768, 0, 0, -32768, 32767, -1, 0, 1, -1));
		directed.push_back(make_xform(0, 0, -32768, 0, -1, 1, 32767, -1, 0, 1));
		directed.push_back(make_xform(32767, -32768, 32767, -32768, 32767, -32768, 32767,
			32'h7fffffff, 32'h80000000, 32'h7fffffff));
		directed.push_back(make_xform(23170, 0, 0, 23170, -256, -512, -128, 100, 200, 300));
		directed.push_back(make_xform(0, 23170, 0, -23170, 0, 0, 0, -100, -200, -300));
		directed.push_back(make_xform(16384, 16384, 16384, 16384, 256, 0, -256,
			32'h00010000, 32'hffff0000, 32'h12345678));
		directed.push_back(make_xform(8192, -4096, 2048, 1024, 1, -1, 2, 5, 6, 7));
		directed.push_back(make_xform(32767, 0, 0, 0, 256, 256, 256, 0, 0, 32'h80000000));
		directed.push_back(make_xform(0, 32767, 0, 0, 256, 256, 256, 0, 32'h7fffffff, 0));
		directed.push_back(make_xform(0, 0, 32767, 0, 512, 384, 128, 32'hdeadbeef, 0, 0));
		directed.push_back(make_xform(1, 1, 1, 1, 32767, 32767, 32767, 1, 1, 1));
		directed.push_back(make_xform(-1, -1, -1, -1, -32768, -32768, -32768, -1, -1, -1));
		directed.push_back(make_xform(-18000, 12000, -9000, 25000, -300, 700, -1200,
			32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f));
		directed.push_back(make_xform(21845, -21846, 10922, -10923, 21845, -21846, 170,
			32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0));

		foreach (directed[i]) begin
			send_transform(directed[i], $urandom_range(0, 19));
		end

		for (int i = 0; i < 410; i++) begin
			phase = (i / 50) % 4;
			sender_calm = (phase == 1) || (phase == 2);
			sink_calm = (phase == 1) || (phase == 3);
			if (i == 205) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (ledger.pending.size() != 0) @(posedge clk);
			end
			send_transform(rand_xform(), sender_calm ? 0 : $urandom_range(0, 19));
		end
		in_valid <= 1'b0;
		sink_calm = 1'b0;

		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);

		if (ledger.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
